FILE: hw/rtl/fat12pte_pkg.sv
package fat12pte_pkg;

    localparam int STORE_BYTES = 8192;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int SUM_W       = ((ADDR_W > 13) ? ADDR_W : 13) + 2;

    localparam logic [11:0] ENTRY_FREE   = 12'h000;
    localparam logic [11:0] FIRST_CLUSTER = 12'd2;
    localparam logic [11:0] LIMIT_RESET  = 12'd2848;
    localparam logic [12:0] BASE_RESET   = 13'd0;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FIND  = 2'd2,
        CMD_RAW   = 2'd3
    } t_cmd;

    typedef enum logic {
        REG_TABLE_BASE   = 1'b0,
        REG_SEARCH_LIMIT = 1'b1
    } t_reg_index;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_RD_A,
        ST_RD_B,
        ST_USE,
        ST_WR_B,
        ST_RAW,
        ST_RAW_DATA,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic calc;
        logic rd_a;
        logic rd_b;
        logic use_b;
        logic wr_b;
        logic raw_rd;
        logic raw_cap;
        logic next_cl;
        logic set_found;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        t_cmd cmd;
        logic entry_zero;
        logic at_limit;
        logic limit_low;
        logic out_free;
    } t_dp_stat;

    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [SUM_W-1:0] a);
        logic [SUM_W-1:0] t;
        t = a;
        if (t >= SUM_W'(STORE_BYTES)) begin
            t = t - SUM_W'(STORE_BYTES);
        end
        if (t >= SUM_W'(STORE_BYTES)) begin
            t = t - SUM_W'(STORE_BYTES);
        end
        return t[ADDR_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/fat12_packed_table_engine.sv
// Channel   Direction  Handshake               Payload
// request   in         i_in_valid / o_in_stall i_cmd, i_cluster, i_value, i_byte_address
// result    out        o_out_valid / i_out_stall o_entry, o_found, o_free_cluster, o_byte_data
// config    in         i_cfg_we                i_cfg_index, i_cfg_data
//
// A request steps through the states CALC, RD_A, RD_B and USE for an entry read,
// adds WR_B for an entry write, goes CALC, RAW, RAW_DATA for a raw byte read, and
// repeats CALC to USE per examined cluster for a free-entry search (none when the
// search limit is below two); the store has one write port and one registered read per cycle.
// After reset the whole store is zeroed one byte per cycle, during which requests
// stall; configuration writes are taken throughout.
// A finished result waits in the output register while the next request is taken.
module fat12_packed_table_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [11:0] i_cluster,
    input  logic [11:0] i_value,
    input  logic [12:0] i_byte_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [11:0] o_entry,
    output logic        o_found,
    output logic [11:0] o_free_cluster,
    output logic [7:0]  o_byte_data
);
    import fat12pte_pkg::*;

    t_dp_cmd  ctl;
    t_dp_stat stat;

    fat12pte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (ctl)
    );

    fat12pte_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_cmd),
        .i_cluster      (i_cluster),
        .i_value        (i_value),
        .i_byte_address (i_byte_address),
        .i_ctl          (ctl),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_entry        (o_entry),
        .o_found        (o_found),
        .o_free_cluster (o_free_cluster),
        .o_byte_data    (o_byte_data)
    );

endmodule

FILE: hw/rtl/fat12pte_ram.sv
module fat12pte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/fat12pte_ctrl.sv
module fat12pte_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  fat12pte_pkg::t_dp_stat i_stat,
    output fat12pte_pkg::t_dp_cmd  o_cmd
);
    import fat12pte_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                if (i_stat.cmd == CMD_RAW) begin
                    n_state = ST_RAW;
                end else if (i_stat.cmd == CMD_FIND && i_stat.limit_low) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_RD_A;
                end
            end
            ST_RD_A: begin
                o_cmd.rd_a = 1'b1;
                n_state = ST_RD_B;
            end
            ST_RD_B: begin
                o_cmd.rd_b = 1'b1;
                n_state = ST_USE;
            end
            ST_USE: begin
                o_cmd.use_b = 1'b1;
                case (i_stat.cmd)
                    CMD_WRITE: n_state = ST_WR_B;
                    CMD_FIND: begin
                        if (i_stat.entry_zero) begin
                            o_cmd.set_found = 1'b1;
                            n_state = ST_DONE;
                        end else if (i_stat.at_limit) begin
                            n_state = ST_DONE;
                        end else begin
                            o_cmd.next_cl = 1'b1;
                            n_state = ST_CALC;
                        end
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_WR_B: begin
                o_cmd.wr_b = 1'b1;
                n_state = ST_DONE;
            end
            ST_RAW: begin
                o_cmd.raw_rd = 1'b1;
                n_state = ST_RAW_DATA;
            end
            ST_RAW_DATA: begin
                o_cmd.raw_cap = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

FILE: hw/rtl/fat12pte_dp.sv
module fat12pte_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [12:0]            i_cfg_data,
    input  logic [1:0]             i_cmd,
    input  logic [11:0]            i_cluster,
    input  logic [11:0]            i_value,
    input  logic [12:0]            i_byte_address,
    input  fat12pte_pkg::t_dp_cmd  i_ctl,
    output fat12pte_pkg::t_dp_stat o_stat,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [11:0]            o_entry,
    output logic                   o_found,
    output logic [11:0]            o_free_cluster,
    output logic [7:0]             o_byte_data
);
    import fat12pte_pkg::*;

    logic [12:0]       r_base;
    logic [11:0]       r_limit;
    logic [ADDR_W-1:0] r_clr_cnt;
    t_cmd              r_cmd;
    logic [11:0]       r_cl;
    logic [11:0]       r_val;
    logic [ADDR_W-1:0] r_raw_addr;
    logic [ADDR_W-1:0] r_addr_a;
    logic [ADDR_W-1:0] r_addr_b;
    logic [7:0]        r_byte_a;
    logic [7:0]        r_byte_b;
    logic [11:0]       r_entry;
    logic              r_found;
    logic [11:0]       r_free;
    logic [7:0]        r_bdata;
    logic              r_out_valid;
    logic [11:0]       r_o_entry;
    logic              r_o_found;
    logic [11:0]       r_o_free;
    logic [7:0]        r_o_bdata;

    logic [13:0]       off3;
    logic [11:0]       cur_entry;
    logic [7:0]        q;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
    logic              odd;

    assign odd  = r_cl[0];
    assign off3 = {1'b0, r_cl, 1'b0} + {2'b00, r_cl};
    assign cur_entry = odd ? {q, r_byte_a[7:4]} : {q[3:0], r_byte_a};

    always_comb begin
        we    = 1'b0;
        waddr = r_addr_a;
        wdata = '0;
        if (i_ctl.clr_step) begin
            we    = 1'b1;
            waddr = r_clr_cnt;
        end else if (i_ctl.use_b && r_cmd == CMD_WRITE) begin
            we    = 1'b1;
            waddr = r_addr_a;
            wdata = odd ? {r_val[3:0], r_byte_a[3:0]} : r_val[7:0];
        end else if (i_ctl.wr_b) begin
            we    = 1'b1;
            waddr = r_addr_b;
            wdata = odd ? r_val[11:4] : {r_byte_b[7:4], r_val[11:8]};
        end
    end

    always_comb begin
        if (i_ctl.rd_b) begin
            raddr = r_addr_b;
        end else if (i_ctl.raw_rd) begin
            raddr = r_raw_addr;
        end else begin
            raddr = r_addr_a;
        end
    end

    fat12pte_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= BASE_RESET;
            r_limit     <= LIMIT_RESET;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_index'(i_cfg_index))
                    REG_TABLE_BASE:   r_base  <= i_cfg_data;
                    REG_SEARCH_LIMIT: r_limit <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (i_ctl.clr_step) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd      <= t_cmd'(i_cmd);
            r_cl       <= (t_cmd'(i_cmd) == CMD_FIND) ? FIRST_CLUSTER : i_cluster;
            r_val      <= i_value;
            r_raw_addr <= wrap_addr(SUM_W'(i_byte_address));
            r_entry    <= '0;
            r_found    <= 1'b0;
            r_free     <= '0;
            r_bdata    <= '0;
        end
        if (i_ctl.calc) begin
            r_addr_a <= wrap_addr(SUM_W'(r_base) + SUM_W'(off3[13:1]));
        end
        if (i_ctl.rd_a) begin
            r_addr_b <= wrap_addr(SUM_W'(r_addr_a) + SUM_W'(1));
        end
        if (i_ctl.rd_b) begin
            r_byte_a <= q;
        end
        if (i_ctl.use_b) begin
            r_byte_b <= q;
            if (r_cmd == CMD_READ) begin
                r_entry <= cur_entry;
            end
        end
        if (i_ctl.set_found) begin
            r_found <= 1'b1;
            r_free  <= r_cl;
        end
        if (i_ctl.next_cl) begin
            r_cl <= r_cl + 1'b1;
        end
        if (i_ctl.raw_cap) begin
            r_bdata <= q;
        end
        if (i_ctl.load_out) begin
            r_o_entry <= r_entry;
            r_o_found <= r_found;
            r_o_free  <= r_free;
            r_o_bdata <= r_bdata;
        end
    end

    assign o_stat.clear_last = (r_clr_cnt == ADDR_W'(STORE_BYTES - 1));
    assign o_stat.cmd        = r_cmd;
    assign o_stat.entry_zero = (cur_entry == ENTRY_FREE);
    assign o_stat.at_limit   = (r_cl == r_limit);
    assign o_stat.limit_low  = (r_limit < FIRST_CLUSTER);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_entry        = r_o_entry;
    assign o_found        = r_o_found;
    assign o_free_cluster = r_o_free;
    assign o_byte_data    = r_o_bdata;

endmodule
